FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the tile RTL; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/core/fgt_pkg.sv
// Types, constants and float helpers for the fp16 GEMM tile.
`timescale 1ns / 1ps
package fgt_pkg;

  localparam int LANES = 4;

  localparam logic [15:0] NAN16 = 16'h7E00;
  localparam logic [31:0] NAN32 = 32'h7FC0_0000;

  typedef logic signed [9:0] exp_t;

  typedef enum logic [1:0] {
    CLS_FIN,
    CLS_INF,
    CLS_NAN
  } fcls_t;

  // value = mag * 2^exp for finite operands
  typedef struct packed {
    fcls_t       cls;
    logic        neg;
    logic [23:0] mag;
    exp_t        exp;
  } fop_t;

  typedef struct packed {
    logic [15:0]                  a;
    logic [LANES-1:0][15:0]       b;
    logic [LANES-1:0][31:0]       c;
    logic                         first;
    logic                         last;
  } item_t;

  function automatic fop_t unpack16(input logic [15:0] bits);
    fop_t       f;
    logic [9:0] ef;
    f.neg = bits[15];
    f.cls = CLS_FIN;
    f.mag = '0;
    f.exp = '0;
    ef    = (bits[14:10] != 5'd0) ? {5'd0, bits[14:10]} : 10'd1;
    if (bits[14:10] == 5'h1F) begin
      f.cls = (bits[9:0] != 10'd0) ? CLS_NAN : CLS_INF;
    end else begin
      f.mag = {13'd0, bits[14:10] != 5'd0, bits[9:0]};
      f.exp = exp_t'(ef) - exp_t'(25);
    end
    return f;
  endfunction

  function automatic fop_t unpack32(input logic [31:0] bits);
    fop_t       f;
    logic [9:0] ef;
    f.neg = bits[31];
    f.cls = CLS_FIN;
    f.mag = '0;
    f.exp = '0;
    ef    = (bits[30:23] != 8'd0) ? {2'd0, bits[30:23]} : 10'd1;
    if (bits[30:23] == 8'hFF) begin
      f.cls = (bits[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
    end else begin
      f.mag = {bits[30:23] != 8'd0, bits[22:0]};
      f.exp = exp_t'(ef) - exp_t'(150);
    end
    return f;
  endfunction

  function automatic logic [31:0] inf_bits(input logic neg, input logic wide);
    return wide ? {neg, 8'hFF, 23'd0} : {16'd0, neg, 5'h1F, 10'd0};
  endfunction

  function automatic logic [31:0] nan_bits(input logic wide);
    return wide ? NAN32 : {16'd0, NAN16};
  endfunction

  function automatic logic [4:0] bit_len24(input logic [23:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(i + 1);
    end
    return n;
  endfunction

  function automatic logic [5:0] bit_len32(input logic [31:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 6'(i + 1);
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/fgt_front.sv
// Input side: takes requests and queues them for the execution side.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fgt_front #(
  parameter int QDEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  fgt_pkg::item_t  in_item,
  output logic            q_valid,
  output fgt_pkg::item_t  q_item,
  input  logic            q_pop
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  fgt_pkg::item_t    mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              push;
  logic              pop;

  assign in_ready = (cnt_r != CNT_W'(QDEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `CHK_IMPLY(a_no_overflow, cnt_r == CNT_W'(QDEPTH), !push)
  `CHK_NEXT(a_cnt_up, push && !pop, cnt_r == CNT_W'($past(cnt_r) + 1'b1))
  `CHK_IMPLY(a_empty_ptrs, cnt_r == '0, wr_ptr_r == rd_ptr_r)

endmodule

FILE: rtl/core/fgt_fadd.sv
// Pipelined two-operand float add with one rounding to fp16 or fp32.
`timescale 1ns / 1ps
module fgt_fadd (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          wide,
  input  fgt_pkg::fop_t op_a,
  input  fgt_pkg::fop_t op_b,
  output logic          done,
  output logic [31:0]   res
);

  localparam fgt_pkg::exp_t EXP_MIN = fgt_pkg::exp_t'(-512);

  // input stage
  logic                v0_r, w0_r, n1_r, n2_r;
  logic [23:0]         m1_r, m2_r;
  fgt_pkg::exp_t       e1_r, e2_r;

  // normalize and order
  logic                vA_r, wA_r, bnegA_r, snegA_r, szeroA_r, bzA_r, bzsA_r;
  logic [31:0]         baA_r, saA_r;
  fgt_pkg::exp_t       btA_r, stA_r;

  // align and add
  logic                vB_r, wB_r, negB_r, bzB_r, bzsB_r;
  logic [31:0]         sumB_r;
  fgt_pkg::exp_t       lsbB_r;

  // leading-one position
  logic                vC_r, wC_r, negC_r, zeroC_r, zsC_r;
  logic [31:0]         sumC_r;
  fgt_pkg::exp_t       rC_r, qC_r;

  // shift to result precision
  logic                vD_r, wD_r, negD_r, zeroD_r, zsD_r, rndD_r, stkD_r;
  logic [31:0]         mD_r;
  fgt_pkg::exp_t       qD_r;

  logic                vE_r;
  logic [31:0]         resE_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      vA_r <= 1'b0;
      vB_r <= 1'b0;
      vC_r <= 1'b0;
      vD_r <= 1'b0;
      vE_r <= 1'b0;
    end else begin
      v0_r <= start;
      vA_r <= v0_r;
      vB_r <= vA_r;
      vC_r <= vB_r;
      vD_r <= vC_r;
      vE_r <= vD_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w0_r <= wide;
      n1_r <= op_a.neg;
      m1_r <= op_a.mag;
      e1_r <= op_a.exp;
      n2_r <= op_b.neg;
      m2_r <= op_b.mag;
      e2_r <= op_b.exp;
    end
  end

  // stage A
  logic [4:0]    len1, len2;
  logic          z1, z2, swap;
  fgt_pkg::exp_t t1, t2;
  logic [31:0]   a1, a2;

  always_comb begin
    len1 = fgt_pkg::bit_len24(m1_r);
    len2 = fgt_pkg::bit_len24(m2_r);
    z1   = (m1_r == '0);
    z2   = (m2_r == '0);
    // a zero term never wins the ordering
    t1   = z1 ? EXP_MIN : e1_r + fgt_pkg::exp_t'({5'd0, len1}) - fgt_pkg::exp_t'(1);
    t2   = z2 ? EXP_MIN : e2_r + fgt_pkg::exp_t'({5'd0, len2}) - fgt_pkg::exp_t'(1);
    a1   = z1 ? '0 : ({8'd0, m1_r} << (6'd31 - {1'b0, len1}));
    a2   = z2 ? '0 : ({8'd0, m2_r} << (6'd31 - {1'b0, len2}));
    swap = (t1 < t2) || ((t1 == t2) && (a1 < a2));
  end

  always_ff @(posedge clk) begin
    wA_r     <= w0_r;
    bnegA_r  <= swap ? n2_r : n1_r;
    baA_r    <= swap ? a2 : a1;
    btA_r    <= swap ? t2 : t1;
    snegA_r  <= swap ? n1_r : n2_r;
    saA_r    <= swap ? a1 : a2;
    stA_r    <= swap ? t1 : t2;
    szeroA_r <= swap ? z1 : z2;
    bzA_r    <= z1 && z2;
    bzsA_r   <= n1_r && n2_r;
  end

  // stage B
  logic signed [10:0] ediff;
  logic [31:0]        lost_mask, al2;

  always_comb begin
    ediff     = {btA_r[9], btA_r} - {stA_r[9], stA_r};
    lost_mask = ~(32'hFFFF_FFFF << ediff[4:0]);
    if (szeroA_r) begin
      al2 = '0;
    end else if (ediff >= 11'sd31) begin
      al2 = 32'd1;
    end else begin
      al2 = (saA_r >> ediff[4:0]) | {31'd0, (saA_r & lost_mask) != '0};
    end
  end

  always_ff @(posedge clk) begin
    wB_r   <= wA_r;
    negB_r <= bnegA_r;
    sumB_r <= (bnegA_r == snegA_r) ? baA_r + al2 : baA_r - al2;
    lsbB_r <= btA_r - fgt_pkg::exp_t'(30);
    bzB_r  <= bzA_r;
    bzsB_r <= bzsA_r;
  end

  // stage C
  logic [5:0]    slen;
  fgt_pkg::exp_t top, emin, topc, qv;

  always_comb begin
    slen = fgt_pkg::bit_len32(sumB_r);
    top  = lsbB_r + fgt_pkg::exp_t'({4'd0, slen}) - fgt_pkg::exp_t'(1);
    emin = wB_r ? fgt_pkg::exp_t'(-126) : fgt_pkg::exp_t'(-14);
    topc = (top > emin) ? top : emin;
    qv   = topc - (wB_r ? fgt_pkg::exp_t'(23) : fgt_pkg::exp_t'(10));
  end

  always_ff @(posedge clk) begin
    wC_r    <= wB_r;
    negC_r  <= negB_r;
    sumC_r  <= sumB_r;
    qC_r    <= qv;
    rC_r    <= qv - lsbB_r;
    zeroC_r <= (sumB_r == '0);
    // exact cancellation gives +0
    zsC_r   <= bzB_r && bzsB_r;
  end

  // stage D
  fgt_pkg::exp_t nr;
  logic [5:0]    rc;
  logic [71:0]   shw;

  always_comb begin
    nr  = -rC_r;
    rc  = (rC_r > fgt_pkg::exp_t'(40)) ? 6'd40 : rC_r[5:0];
    shw = {sumC_r, 40'd0} >> rc;
  end

  always_ff @(posedge clk) begin
    wD_r    <= wC_r;
    negD_r  <= negC_r;
    zeroD_r <= zeroC_r;
    zsD_r   <= zsC_r;
    qD_r    <= qC_r;
    if (rC_r <= fgt_pkg::exp_t'(0)) begin
      mD_r   <= sumC_r << nr[4:0];
      rndD_r <= 1'b0;
      stkD_r <= 1'b0;
    end else begin
      mD_r   <= shw[71:40];
      rndD_r <= shw[39];
      stkD_r <= (shw[38:0] != '0);
    end
  end

  // stage E: round, renormalize, pack
  logic          up, ovf, hidden;
  logic [32:0]   m2, m3;
  fgt_pkg::exp_t q2, biased, maxb;
  logic [31:0]   packed_res;

  always_comb begin
    up     = rndD_r && (stkD_r || mD_r[0]);
    m2     = {1'b0, mD_r} + {32'd0, up};
    ovf    = wD_r ? m2[24] : m2[11];
    m3     = ovf ? (m2 >> 1) : m2;
    q2     = ovf ? qD_r + fgt_pkg::exp_t'(1) : qD_r;
    hidden = wD_r ? m3[23] : m3[10];
    biased = q2 + (wD_r ? fgt_pkg::exp_t'(150) : fgt_pkg::exp_t'(25));
    maxb   = wD_r ? fgt_pkg::exp_t'(255) : fgt_pkg::exp_t'(31);
    if (zeroD_r) begin
      packed_res = wD_r ? {zsD_r, 31'd0} : {16'd0, zsD_r, 15'd0};
    end else if (m3 == '0) begin
      packed_res = wD_r ? {negD_r, 31'd0} : {16'd0, negD_r, 15'd0};
    end else if (hidden) begin
      if (biased >= maxb) begin
        packed_res = fgt_pkg::inf_bits(negD_r, wD_r);
      end else if (wD_r) begin
        packed_res = {negD_r, biased[7:0], m3[22:0]};
      end else begin
        packed_res = {16'd0, negD_r, biased[4:0], m3[9:0]};
      end
    end else if (wD_r) begin
      packed_res = {negD_r, 8'd0, m3[22:0]};
    end else begin
      packed_res = {16'd0, negD_r, 5'd0, m3[9:0]};
    end
  end

  always_ff @(posedge clk) begin
    resE_r <= packed_res;
  end

  assign done = vE_r;
  assign res  = resE_r;

endmodule

FILE: rtl/core/fgt_back.sv
// Execution side: lane multiply-adds, group flush into the accumulators, result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fgt_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  wide,
  input  logic                                  q_valid,
  input  fgt_pkg::item_t                        q_item,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [fgt_pkg::LANES-1:0][31:0]       out_c
);

  localparam int L = fgt_pkg::LANES;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FMA,
    S_ACC,
    S_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [15:0]           a_r;
  logic [L-1:0][15:0]    b_r;
  logic                  last_r;
  logic [L-1:0][31:0]    acc_r;
  logic [L-1:0][15:0]    part_r;
  logic [1:0]            grp_r;
  fgt_pkg::fop_t         prod_r   [L];
  logic [L-1:0]          spec_r;
  logic [L-1:0][31:0]    specv_r;
  logic                  busy_r;
  logic                  out_valid_r;
  logic [L-1:0][31:0]    out_c_r;

  fgt_pkg::fop_t         ua;
  fgt_pkg::fop_t         op_a     [L];
  fgt_pkg::fop_t         op_b     [L];
  fgt_pkg::fop_t         prod_l   [L];
  logic [L-1:0]          fspec_l, aspec_l;
  logic [L-1:0][31:0]    fspecv_l, aspecv_l;
  logic [L-1:0][31:0]    res_l;
  logic [L-1:0]          done_v;
  logic                  add_done, add_start, add_wide, out_load;

  assign ua        = fgt_pkg::unpack16(a_r);
  assign add_done  = done_v[0];
  assign add_start = ((state_r == S_FMA) || (state_r == S_ACC)) && !busy_r;
  assign add_wide  = (state_r == S_ACC) && wide;
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_ready);
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  for (genvar l = 0; l < L; l++) begin : g_lane
    fgt_pkg::fop_t ub, uc, ux, uy;
    logic          pn;
    logic [21:0]   pm;

    always_comb begin
      ub = fgt_pkg::unpack16(b_r[l]);
      uc = fgt_pkg::unpack16(part_r[l]);
      ux = wide ? fgt_pkg::unpack32(acc_r[l]) : fgt_pkg::unpack16(acc_r[l][15:0]);
      uy = uc;
      pn = ua.neg ^ ub.neg;
      pm = ua.mag[10:0] * ub.mag[10:0];

      prod_l[l].cls = fgt_pkg::CLS_FIN;
      prod_l[l].neg = pn;
      prod_l[l].mag = {2'd0, pm};
      prod_l[l].exp = ua.exp + ub.exp;

      // inf*0 and opposing infinities give the default NaN
      fspec_l[l]  = 1'b1;
      fspecv_l[l] = fgt_pkg::nan_bits(1'b0);
      if (ua.cls == fgt_pkg::CLS_NAN || ub.cls == fgt_pkg::CLS_NAN ||
          uc.cls == fgt_pkg::CLS_NAN) begin
        fspecv_l[l] = fgt_pkg::nan_bits(1'b0);
      end else if (ua.cls == fgt_pkg::CLS_INF || ub.cls == fgt_pkg::CLS_INF) begin
        if ((ua.cls == fgt_pkg::CLS_FIN && ua.mag == '0) ||
            (ub.cls == fgt_pkg::CLS_FIN && ub.mag == '0) ||
            (uc.cls == fgt_pkg::CLS_INF && uc.neg != pn)) begin
          fspecv_l[l] = fgt_pkg::nan_bits(1'b0);
        end else begin
          fspecv_l[l] = fgt_pkg::inf_bits(pn, 1'b0);
        end
      end else if (uc.cls == fgt_pkg::CLS_INF) begin
        fspecv_l[l] = fgt_pkg::inf_bits(uc.neg, 1'b0);
      end else begin
        fspec_l[l] = 1'b0;
      end

      aspec_l[l]  = 1'b1;
      aspecv_l[l] = fgt_pkg::nan_bits(wide);
      if (ux.cls == fgt_pkg::CLS_NAN || uy.cls == fgt_pkg::CLS_NAN) begin
        aspecv_l[l] = fgt_pkg::nan_bits(wide);
      end else if (ux.cls == fgt_pkg::CLS_INF && uy.cls == fgt_pkg::CLS_INF &&
                   ux.neg != uy.neg) begin
        aspecv_l[l] = fgt_pkg::nan_bits(wide);
      end else if (ux.cls == fgt_pkg::CLS_INF) begin
        aspecv_l[l] = fgt_pkg::inf_bits(ux.neg, wide);
      end else if (uy.cls == fgt_pkg::CLS_INF) begin
        aspecv_l[l] = fgt_pkg::inf_bits(uy.neg, wide);
      end else begin
        aspec_l[l] = 1'b0;
      end

      op_a[l] = (state_r == S_ACC) ? ux : prod_r[l];
      op_b[l] = (state_r == S_ACC) ? uy : uc;
    end

    fgt_fadd u_fadd (
      .clk   (clk),
      .rst_n (rst_n),
      .start (add_start),
      .wide  (add_wide),
      .op_a  (op_a[l]),
      .op_b  (op_b[l]),
      .done  (done_v[l]),
      .res   (res_l[l])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_FMA;
      S_FMA: begin
        if (add_done) state_nxt = ((grp_r == 2'd3) || last_r) ? S_ACC : S_IDLE;
      end
      S_ACC: begin
        if (add_done) state_nxt = last_r ? S_EMIT : S_IDLE;
      end
      S_EMIT: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      grp_r       <= '0;
      part_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (add_start) busy_r <= 1'b1;
      else if (add_done) busy_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            a_r    <= q_item.a;
            b_r    <= q_item.b;
            last_r <= q_item.last;
            if (q_item.first) begin
              for (int l = 0; l < L; l++) begin
                acc_r[l] <= wide ? q_item.c[l] : {16'd0, q_item.c[l][15:0]};
              end
              part_r <= '0;
              grp_r  <= '0;
            end
          end
        end
        S_MUL: begin
          for (int l = 0; l < L; l++) begin
            prod_r[l]  <= prod_l[l];
            spec_r[l]  <= fspec_l[l];
            specv_r[l] <= fspecv_l[l];
          end
        end
        S_FMA: begin
          if (add_done) begin
            for (int l = 0; l < L; l++) begin
              part_r[l] <= spec_r[l] ? specv_r[l][15:0] : res_l[l][15:0];
            end
            grp_r <= grp_r + 1'b1;
          end
        end
        S_ACC: begin
          if (add_start) begin
            spec_r  <= aspec_l;
            specv_r <= aspecv_l;
          end
          if (add_done) begin
            for (int l = 0; l < L; l++) begin
              acc_r[l] <= spec_r[l] ? specv_r[l] : res_l[l];
            end
            part_r <= '0;
            grp_r  <= '0;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            for (int l = 0; l < L; l++) begin
              out_c_r[l] <= wide ? acc_r[l] : {16'd0, acc_r[l][15:0]};
            end
          end
        end
        default: ;
      endcase

      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_c     = out_c_r;

  `CHK_IMPLY(a_done_busy, add_done, busy_r)
  `CHK_IMPLY(a_lanes_sync, done_v != '0, done_v == {L{1'b1}})
  `CHK_NEXT(a_pop_to_mul, q_pop, state_r == S_MUL)
  `CHK_IMPLY(a_emit_last, state_r == S_EMIT, last_r)

endmodule

FILE: rtl/core/fp16_gemm_row_by_four_tile.sv
// Top level of the fp16 1x4 GEMM tile: config register, request queue, execution side.
`timescale 1ns / 1ps
// One request carries A, four B values and four initial C values for one k step.
// Requests queue in front (QDEPTH deep) while the execution side works; each k
// step there consists of a queue pop, an 11x11 multiply, then an issue into and a run
// through the 6-stage add-and-round in every lane, and a step that closes a
// group of four or carries last_step adds the accumulator add through the same
// adder, plus a load of the result register on last_step (held back while the
// previous result still waits on out_ready). The fp16 partial-sum feedback
// through the adder keeps the execution side from taking a new request before
// the previous step is done. cfg_wdata selects fp16 (0) or fp32 (1) accumulation.
module fp16_gemm_row_by_four_tile #(
  parameter int QDEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_a_value,
  input  logic [15:0] in_b_lane0,
  input  logic [15:0] in_b_lane1,
  input  logic [15:0] in_b_lane2,
  input  logic [15:0] in_b_lane3,
  input  logic [31:0] in_c_in_lane0,
  input  logic [31:0] in_c_in_lane1,
  input  logic [31:0] in_c_in_lane2,
  input  logic [31:0] in_c_in_lane3,
  input  logic        in_first_step,
  input  logic        in_last_step,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_c_lane0,
  output logic [31:0] out_c_lane1,
  output logic [31:0] out_c_lane2,
  output logic [31:0] out_c_lane3
);

  logic                                  accum_format_r;
  fgt_pkg::item_t                        in_item, q_item;
  logic                                  q_valid, q_pop;
  logic [fgt_pkg::LANES-1:0][31:0]       out_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_format_r <= 1'b0;
    end else if (cfg_we) begin
      accum_format_r <= cfg_wdata;
    end
  end

  always_comb begin
    in_item.a     = in_a_value;
    in_item.b[0]  = in_b_lane0;
    in_item.b[1]  = in_b_lane1;
    in_item.b[2]  = in_b_lane2;
    in_item.b[3]  = in_b_lane3;
    in_item.c[0]  = in_c_in_lane0;
    in_item.c[1]  = in_c_in_lane1;
    in_item.c[2]  = in_c_in_lane2;
    in_item.c[3]  = in_c_in_lane3;
    in_item.first = in_first_step;
    in_item.last  = in_last_step;
  end

  fgt_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  fgt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wide      (accum_format_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_c     (out_c)
  );

  assign out_c_lane0 = out_c[0];
  assign out_c_lane1 = out_c[1];
  assign out_c_lane2 = out_c[2];
  assign out_c_lane3 = out_c[3];

endmodule

FILE: tb/fp16_gemm_row_by_four_tile_tb.sv
// Self-checking testbench for the fp16 1x4 GEMM tile with a bit-exact float predictor.
`timescale 1ns / 1ps
module fp16_gemm_row_by_four_tile_tb;

  localparam int LANES      = fgt_pkg::LANES;
  localparam int GROUP_LEN  = 4;
  localparam int DRAIN_WAIT = 60;
  localparam logic FMT_HALF = 1'b0;
  localparam logic FMT_WIDE = 1'b1;

  typedef struct {
    fgt_pkg::fcls_t  cls;
    bit              neg;
    longint unsigned mag;
    int              ex;
  } fnum_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_a_value = '0;
  logic [15:0] in_b [LANES] = '{default: '0};
  logic [31:0] in_c [LANES] = '{default: '0};
  logic        in_first_step = 1'b0;
  logic        in_last_step = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_c [LANES];

  fp16_gemm_row_by_four_tile u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_value(in_a_value),
    .in_b_lane0(in_b[0]), .in_b_lane1(in_b[1]), .in_b_lane2(in_b[2]), .in_b_lane3(in_b[3]),
    .in_c_in_lane0(in_c[0]), .in_c_in_lane1(in_c[1]),
    .in_c_in_lane2(in_c[2]), .in_c_in_lane3(in_c[3]),
    .in_first_step(in_first_step), .in_last_step(in_last_step),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_c_lane0(out_c[0]), .out_c_lane1(out_c[1]),
    .out_c_lane2(out_c[2]), .out_c_lane3(out_c[3])
  );

  always #6 clk = ~clk;

  // predictor state
  logic        fmt_wide;
  logic [1:0]  grp_pos;
  logic [15:0] lane_part [LANES];
  logic [31:0] lane_acc [LANES];
  logic [31:0] tile_q [$][LANES];

  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic int bit_count(longint unsigned v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    return n;
  endfunction

  function automatic fnum_t decode(logic [31:0] bits, int p, int ew);
    fnum_t f;
    int emaxf, bias, ef;
    longint unsigned fr;
    emaxf = (1 << ew) - 1;
    bias  = (1 << (ew - 1)) - 1;
    ef    = int'((bits >> p) & emaxf);
    fr    = bits & ((32'd1 << p) - 1);
    f.neg = bits[p + ew];
    f.cls = fgt_pkg::CLS_FIN;
    f.mag = 0;
    f.ex  = 0;
    if (ef == emaxf) begin
      f.cls = (fr != 0) ? fgt_pkg::CLS_NAN : fgt_pkg::CLS_INF;
    end else begin
      f.mag = (ef != 0) ? (fr | (64'd1 << p)) : fr;
      f.ex  = ((ef != 0) ? ef : 1) - bias - p;
    end
    return f;
  endfunction

  function automatic logic [31:0] inf_of(bit neg, int p, int ew);
    return (32'(neg) << (p + ew)) | (((32'd1 << ew) - 1) << p);
  endfunction

  function automatic logic [31:0] qnan_of(int p, int ew);
    return inf_of(1'b0, p, ew) | (32'd1 << (p - 1));
  endfunction

  function automatic logic [31:0] round_to(bit neg, longint unsigned mag, int ex, int p, int ew);
    logic [31:0]     sign;
    int              bias, emin, top, q, r, biased;
    longint unsigned m, rem, half;
    bit              up;
    sign = 32'(neg) << (p + ew);
    bias = (1 << (ew - 1)) - 1;
    emin = 1 - bias;
    up   = 1'b0;
    if (mag == 0) return sign;
    top = ex + bit_count(mag) - 1;
    q   = ((top > emin) ? top : emin) - p;
    r   = q - ex;
    if (r <= 0) begin
      m = mag << (-r);
    end else if (r < 64) begin
      rem  = mag & ((64'd1 << r) - 1);
      half = 64'd1 << (r - 1);
      m    = mag >> r;
      up   = (rem > half) || (rem == half && m[0]);
    end else if (r == 64) begin
      m  = 0;
      up = mag > (64'd1 << 63);
    end else begin
      m = 0;
    end
    if (up) m++;
    if ((m >> (p + 1)) != 0) begin
      m >>= 1;
      q++;
    end
    if (m == 0) return sign;
    if (m >= (64'd1 << p)) begin
      biased = q + p + bias;
      if (biased >= (1 << ew) - 1) return inf_of(neg, p, ew);
      return sign | (32'(biased) << p) | 32'(m - (64'd1 << p));
    end
    return sign | 32'(m);
  endfunction

  function automatic logic [31:0] sum_round(bit n1, longint unsigned m1, int e1,
                                            bit n2, longint unsigned m2, int e2, int p, int ew);
    int              t1, t2, d, tt;
    longint unsigned a1, a2, s, ta, lost;
    bit              tn;
    if (m1 == 0 && m2 == 0) return round_to(n1 && n2, 0, 0, p, ew);
    if (m1 == 0) return round_to(n2, m2, e2, p, ew);
    if (m2 == 0) return round_to(n1, m1, e1, p, ew);
    t1 = e1 + bit_count(m1) - 1;
    t2 = e2 + bit_count(m2) - 1;
    a1 = m1 << (63 - bit_count(m1));
    a2 = m2 << (63 - bit_count(m2));
    if (t1 < t2 || (t1 == t2 && a1 < a2)) begin
      ta = a1; tt = t1; tn = n1;
      a1 = a2; t1 = t2; n1 = n2;
      a2 = ta; t2 = tt; n2 = tn;
    end
    d = t1 - t2;
    if (d >= 63) begin
      a2 = 1;
    end else if (d > 0) begin
      lost = a2 & ((64'd1 << d) - 1);
      a2   = (a2 >> d) | ((lost != 0) ? 64'd1 : 64'd0);
    end
    s = (n1 == n2) ? a1 + a2 : a1 - a2;
    if (s == 0) return round_to(1'b0, 0, 0, p, ew);
    return round_to(n1, s, t1 - 62, p, ew);
  endfunction

  function automatic logic [15:0] half_fma(logic [15:0] a, logic [15:0] b, logic [15:0] c);
    fnum_t fa, fb, fc;
    bit    pn;
    fa = decode(32'(a), 10, 5);
    fb = decode(32'(b), 10, 5);
    fc = decode(32'(c), 10, 5);
    pn = fa.neg ^ fb.neg;
    if (fa.cls == fgt_pkg::CLS_NAN || fb.cls == fgt_pkg::CLS_NAN ||
        fc.cls == fgt_pkg::CLS_NAN) return fgt_pkg::NAN16;
    if (fa.cls == fgt_pkg::CLS_INF || fb.cls == fgt_pkg::CLS_INF) begin
      if ((fa.cls == fgt_pkg::CLS_FIN && fa.mag == 0) ||
          (fb.cls == fgt_pkg::CLS_FIN && fb.mag == 0)) return fgt_pkg::NAN16;
      if (fc.cls == fgt_pkg::CLS_INF && fc.neg != pn) return fgt_pkg::NAN16;
      return 16'(inf_of(pn, 10, 5));
    end
    if (fc.cls == fgt_pkg::CLS_INF) return 16'(inf_of(fc.neg, 10, 5));
    return 16'(sum_round(pn, fa.mag * fb.mag, fa.ex + fb.ex, fc.neg, fc.mag, fc.ex, 10, 5));
  endfunction

  function automatic logic [31:0] acc_add(logic [31:0] acc, logic [15:0] part, int p, int ew);
    fnum_t x, y;
    x = decode(acc, p, ew);
    y = decode(32'(part), 10, 5);
    if (x.cls == fgt_pkg::CLS_NAN || y.cls == fgt_pkg::CLS_NAN) return qnan_of(p, ew);
    if (x.cls == fgt_pkg::CLS_INF && y.cls == fgt_pkg::CLS_INF && x.neg != y.neg)
      return qnan_of(p, ew);
    if (x.cls == fgt_pkg::CLS_INF) return inf_of(x.neg, p, ew);
    if (y.cls == fgt_pkg::CLS_INF) return inf_of(y.neg, p, ew);
    return sum_round(x.neg, x.mag, x.ex, y.neg, y.mag, y.ex, p, ew);
  endfunction

  // update tile state for one accepted request; queue the tile if it closes
  task automatic tile_step();
    int          p, ew;
    logic [31:0] mask;
    logic [31:0] res [LANES];
    p    = fmt_wide ? 23 : 10;
    ew   = fmt_wide ? 8 : 5;
    mask = fmt_wide ? 32'hFFFF_FFFF : 32'h0000_FFFF;
    if (in_first_step) begin
      for (int l = 0; l < LANES; l++) begin
        lane_acc[l]  = in_c[l] & mask;
        lane_part[l] = '0;
      end
      grp_pos = '0;
    end
    for (int l = 0; l < LANES; l++) lane_part[l] = half_fma(in_a_value, in_b[l], lane_part[l]);
    if (int'(grp_pos) + 1 >= GROUP_LEN || in_last_step) begin
      for (int l = 0; l < LANES; l++) begin
        lane_acc[l]  = acc_add(lane_acc[l] & mask, lane_part[l], p, ew) & mask;
        lane_part[l] = '0;
      end
      grp_pos = '0;
    end else begin
      grp_pos = grp_pos + 2'd1;
    end
    if (in_last_step) begin
      for (int l = 0; l < LANES; l++) res[l] = lane_acc[l] & mask;
      tile_q.push_back(res);
    end
  endtask

  task automatic send_request(logic [15:0] a, logic [15:0] b [LANES], logic [31:0] c [LANES],
                              bit first, bit last);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_a_value    = a;
    in_b          = b;
    in_c          = c;
    in_first_step = first;
    in_last_step  = last;
    do @(posedge clk); while (!in_ready);
    tile_step();
  endtask

  // idle the input and wait until every tile result is back and the pipe is empty
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tile_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_format(logic wide);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = wide;
    @(negedge clk);
    cfg_we   = 1'b0;
    fmt_wide = wide;
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (tile_q.size() == 0) begin
        $display("%0t: unexpected result %h %h %h %h", $time,
                 out_c[0], out_c[1], out_c[2], out_c[3]);
        errors++;
      end else begin
        for (int l = 0; l < LANES; l++) begin
          if (out_c[l] !== tile_q[0][l]) begin
            $display("%0t: lane %0d expected %h actual %h", $time, l, tile_q[0][l], out_c[l]);
            errors++;
          end
        end
        void'(tile_q.pop_front());
      end
    end
  end

  function automatic logic [15:0] rand_half();
    case ($urandom_range(9))
      0: return {1'($urandom_range(1)), 15'd0};
      1: return {1'($urandom_range(1)), 5'h1F, 10'd0};
      2: return {1'($urandom_range(1)), 5'h1F, 10'($urandom_range(1023, 1))};
      3: return {1'($urandom_range(1)), 5'd0, 10'($urandom())};
      8, 9: return 16'($urandom());
      default: return {1'($urandom_range(1)), 5'($urandom_range(20, 10)), 10'($urandom())};
    endcase
  endfunction

  function automatic logic [31:0] rand_c();
    case ($urandom_range(11))
      0: return {1'($urandom_range(1)), 31'd0};
      1: return {1'($urandom_range(1)), 8'hFF, 23'd0};
      2: return {1'($urandom_range(1)), 8'hFF, 23'($urandom_range(8388607, 1))};
      3: return {1'($urandom_range(1)), 8'd0, 23'($urandom())};
      4, 5: return {16'($urandom()), rand_half()};
      6: return $urandom();
      default: return {1'($urandom_range(1)), 8'($urandom_range(140, 112)), 23'($urandom())};
    endcase
  endfunction

  // one request with random data
  task automatic rand_request(bit first, bit last);
    logic [15:0] b [LANES];
    logic [31:0] c [LANES];
    for (int l = 0; l < LANES; l++) begin
      b[l] = rand_half();
      c[l] = rand_c();
    end
    send_request(rand_half(), b, c, first, last);
  endtask

  task automatic half_request(logic [15:0] a, logic [15:0] bv, logic [31:0] cv, bit first, bit last);
    logic [15:0] b [LANES];
    logic [31:0] c [LANES];
    for (int l = 0; l < LANES; l++) begin
      b[l] = bv ^ 16'(l);
      c[l] = cv;
    end
    b[3] = bv;
    send_request(a, b, c, first, last);
  endtask

  task automatic test_directed();
    // plain group of four, then a tile cut short after two steps
    half_request(16'h3C00, 16'h4000, 32'hFFFF_3C00, 1, 0);
    half_request(16'h3C00, 16'h4000, 32'h0, 0, 0);
    half_request(16'hBC00, 16'h3800, 32'h0, 0, 0);
    half_request(16'h3555, 16'h3555, 32'h0, 0, 1);
    half_request(16'h7BFF, 16'h7BFF, 32'h0000_7BFF, 1, 0);
    half_request(16'h0001, 16'h8001, 32'h0, 0, 1);
    // inf * 0, inf - inf, nan operand, overflow
    half_request(16'h7C00, 16'h0000, 32'h0, 1, 1);
    half_request(16'h7C00, 16'h3C00, 32'h0000_FC00, 1, 1);
    half_request(16'hFE01, 16'h3C00, 32'h0, 1, 1);
    half_request(16'h7BFF, 16'h4000, 32'h0000_7BFF, 1, 1);
    // exact cancellation gives +0
    half_request(16'h3C00, 16'h3C00, 32'h0000_BC00, 1, 1);
    // no first_step: accumulators keep running over two tiles
    half_request(16'h3C00, 16'h3E00, 32'h0, 0, 1);
    half_request(16'h03FF, 16'h7800, 32'h0, 0, 1);
    half_request(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1, 1);
    // mode change with a tile still open
    half_request(16'h4400, 16'h4400, 32'h0000_4400, 1, 0);
    set_format(FMT_WIDE);
    half_request(16'h4400, 16'h4400, 32'h0, 0, 1);
    half_request(16'h7BFF, 16'h7BFF, 32'h7F7F_FFFF, 1, 1);
    half_request(16'h3C00, 16'h3C00, 32'hFF80_0000, 1, 1);
    half_request(16'h0001, 16'h0001, 32'h0000_0001, 1, 1);
    set_format(FMT_HALF);
  endtask

  // mostly well-formed tiles, some with stray first/last flags
  task automatic test_random(int n, int s_idle, int r_idle);
    int sent, len;
    bit noisy;
    send_idle = s_idle;
    recv_idle = r_idle;
    sent = 0;
    while (sent < n) begin
      len   = ($urandom_range(3) == 0) ? $urandom_range(1, 7) : 4 * $urandom_range(1, 3);
      noisy = ($urandom_range(9) == 0);
      for (int k = 0; k < len; k++) begin
        if (noisy) rand_request(1'($urandom_range(1)), 1'($urandom_range(3) == 0));
        else rand_request(k == 0, k == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_hold_off();
    send_idle = 0;
    recv_idle = 30;
    for (int k = 0; k < 8; k++) rand_request(k == 0, k == 7);
    @(negedge clk);
    in_valid = 1'b0;
    while (tile_q.size() != 0) @(negedge clk);
    for (int k = 0; k < 4; k++) rand_request(k == 0, k == 3);
  endtask

  initial begin
    fmt_wide  = FMT_HALF;
    grp_pos   = '0;
    lane_part = '{default: '0};
    lane_acc  = '{default: '0};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random(440, 8, 57);
    set_format(FMT_WIDE);
    test_random(440, 57, 8);
    test_hold_off();
    set_format(FMT_HALF);
    test_random(220, 0, 0);
    set_format(FMT_WIDE);
    test_random(220, 0, 0);
    drain();
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/fgt_pkg.sv
rtl/core/fgt_front.sv
rtl/core/fgt_fadd.sv
rtl/core/fgt_back.sv
rtl/core/fp16_gemm_row_by_four_tile.sv
tb/fp16_gemm_row_by_four_tile_tb.sv
